// File: rtl/cfra_pkg.sv
package cfra_pkg;
	localparam int MAX_TERMS_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam logic [3:0] MAX_RECIP_RESET = 4'd10;
	localparam int THOUSANDTHS = 1000;
	localparam int HUNDREDTH_STEP = 100;
endpackage

// File: rtl/continued_fraction_rational_approx.sv
// Sequence: the first term, the integer part of the input, passes ST_MULH and ST_MULK; each
// reciprocal step then runs ST_DIV, ST_CHK, ST_MULH and ST_MULK, for up to
// min(max(max_reciprocals, 1), MAX_TERMS-1) steps. One request at a time; the next can be
// taken no earlier than the cycle after the result has been delivered.
// The serial restoring divider (one quotient bit per cycle) takes most of each step.
// Reset (arst_n low, asynchronous) empties the block and sets max_reciprocals to 10.
module continued_fraction_rational_approx #(
	parameter int MAX_TERMS = cfra_pkg::MAX_TERMS_DEF,
	parameter int FRAC_BITS = cfra_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // value[31:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // numerator[31:0], denominator[63:32], term_count[68:64],
	                               // overflow[69], zeros[71:70]
);
	import cfra_pkg::*;

	localparam int QW = 2 * FRAC_BITS + 1;           // quotient width, r <= 2^(2F)
	localparam int CW = $clog2(2 * FRAC_BITS + 2);
	localparam int TW = QW + 10 - FRAC_BITS;         // width of the thousandths value
	localparam int DS = TW + 7;                      // shift of the divide-by-hundred multiply
	localparam logic [TW:0] DIV_MAGIC = (TW+1)'(((64'd1 << DS) + 64'(HUNDREDTH_STEP) - 64'd1)
		/ 64'(HUNDREDTH_STEP));

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIV  = 6'b000010,
		ST_MULH = 6'b000100,
		ST_MULK = 6'b001000,
		ST_CHK  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	logic [3:0] max_recip_q;
	logic [FRAC_BITS-1:0] f_q;
	logic [FRAC_BITS-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] bit_q;
	logic [4:0] recip_q;
	logic [5:0] count_q;
	logic signed [33:0] term_q;
	logic signed [33:0] h1_q, h2_q, k1_q, k2_q;
	logic ovf_q;
	logic [3:0] limit;
	logic [FRAC_BITS:0] rem_sh;
	logic signed [67:0] prod;
	logic signed [67:0] h_sum;
	logic [QW+9:0] thou_full;
	logic [QW+9-FRAC_BITS:0] thou;
	logic [TW-1:0] thou_q;
	logic [2*TW:0] quot_full;
	logic [TW-7:0] quot_q;
	logic [TW-1:0] quot_back;
	logic thou_zero;
	logic signed [33:0] h_sat;
	logic h_ov;

	// Effective reciprocal limit.
	always_comb begin
		limit = (max_recip_q == 4'd0) ? 4'd1 : max_recip_q;
		if (32'(limit) > MAX_TERMS - 1) limit = 4'(MAX_TERMS - 1);
	end

	// Dividend bit: the dividend 2^(2F) has a single one at the top.
	assign rem_sh = {rem_q[FRAC_BITS-1:0], (bit_q == CW'(2 * FRAC_BITS))};

	// Shared multiply-add: term times previous plus one before.
	always_comb begin
		if (state_q == ST_MULH) begin
			prod = term_q * h1_q;
			h_sum = prod + 68'(h2_q);
		end else begin
			prod = term_q * k1_q;
			h_sum = prod + 68'(k2_q);
		end
		h_ov = 1'b0;
		h_sat = h_sum[33:0];
		if (state_q == ST_MULH) begin
			if (h_sum > 68'sd2147483647) begin h_sat = 34'sd2147483647; h_ov = 1'b1; end
			else if (h_sum < -68'sd2147483648) begin h_sat = -34'sd2147483648; h_ov = 1'b1; end
		end else begin
			if (h_sum > 68'sd4294967295) begin h_sat = 34'sd4294967295; h_ov = 1'b1; end
			else if (h_sum < 68'sd0) begin h_sat = 34'sd0; h_ov = 1'b1; end
		end
	end

	// Thousandths of the reciprocal and its hundredths digits test. The quotient by a
	// hundred comes from a reciprocal multiply, and the digits are zero when it scales back.
	always_comb begin
		thou_full = (QW+10)'(quo_q) * (QW+10)'(THOUSANDTHS);
		thou = thou_full[QW+9:FRAC_BITS];
		quot_full = (2*TW+1)'(thou_q) * (2*TW+1)'(DIV_MAGIC);
		quot_back = TW'(quot_q) * TW'(HUNDREDTH_STEP);
		thou_zero = (quot_back == thou_q);
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_recip_q <= MAX_RECIP_RESET;
		end else if (cfg_we) begin
			max_recip_q <= cfg_wdata;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						f_q <= s_tdata[FRAC_BITS-1:0];
						term_q <= 34'(signed'(s_tdata) >>> FRAC_BITS);
						h1_q <= 34'sd1; h2_q <= 34'sd0; k1_q <= 34'sd0; k2_q <= 34'sd1;
						count_q <= 6'd0; recip_q <= 5'd0; ovf_q <= 1'b0;
						state_q <= ST_MULH;
					end
				end
				ST_DIV: begin
					if (rem_sh >= {1'b0, f_q}) begin
						rem_q <= FRAC_BITS'(rem_sh - {1'b0, f_q});
						quo_q <= {quo_q[QW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[FRAC_BITS-1:0];
						quo_q <= {quo_q[QW-2:0], 1'b0};
					end
					if (bit_q == CW'(0)) state_q <= ST_CHK;
					bit_q <= bit_q - CW'(1);
				end
				ST_CHK: begin
					term_q <= 34'(quo_q >> FRAC_BITS);
					f_q <= quo_q[FRAC_BITS-1:0];
					thou_q <= thou;
					recip_q <= recip_q + 5'd1;
					state_q <= ST_MULH;
				end
				ST_MULH: begin
					h2_q <= h1_q; h1_q <= h_sat;
					ovf_q <= ovf_q | h_ov;
					quot_q <= quot_full[2*TW:DS];
					state_q <= ST_MULK;
				end
				ST_MULK: begin
					k2_q <= k1_q; k1_q <= h_sat;
					ovf_q <= ovf_q | h_ov;
					count_q <= count_q + 6'd1;
					if (f_q == '0 || (recip_q != 5'd0 &&
					    (recip_q >= {1'b0, limit} || thou_zero))) begin
						m_tvalid <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						rem_q <= '0;
						quo_q <= '0;
						bit_q <= CW'(2 * FRAC_BITS);
						state_q <= ST_DIV;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tdata = {2'b00, ovf_q, count_q[4:0], k1_q[31:0], h1_q[31:0]};
endmodule
